/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DHS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is high.
`define DHS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* sv/dhs_pkg.sv */
// Types, codes and default sizes for the dedup hash set.
`timescale 1ns / 1ps
package dhs_pkg;

   localparam int OP_W    = 2;
   localparam int VALUE_W = 64;
   localparam int COUNT_W = 11;

   localparam int DEF_TABLE_ENTRIES = 1024;
   localparam int DEF_BANK_NODES    = 1024;
   localparam int DEF_HASH_SHIFT    = 4;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_INSERT,
      KIND_QUERY,
      KIND_REMOVE,
      KIND_CLEAR
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [VALUE_W-1:0]   value;
   } cmd_type;

   typedef struct packed {
      logic                 was_present;
      logic                 was_added;
      logic                 overflowed;
      logic [COUNT_W-1:0]   live_entries;
      logic [COUNT_W-1:0]   garbage_entries;
   } rsp_type;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_HEAD,
      S_NODE,
      S_DECIDE,
      S_GC_HEAD,
      S_GC_NODE,
      S_GC_NEXT,
      S_GC_DONE
   } back_state_type;

endpackage

/* sv/dhs_front.sv */
// Front end: takes request words and classifies them into commands.
`timescale 1ns / 1ps
module dhs_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [dhs_pkg::OP_W-1:0]     req_operation,
   input  logic [dhs_pkg::VALUE_W-1:0]  req_value,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output dhs_pkg::cmd_type             cmd_data
);
   import dhs_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    load;

   assign req_ready = !valid_ff || cmd_ready;
   assign load      = req_valid && req_ready;
   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;

   always_comb begin
      valid_in     = valid_ff;
      cmd_in       = cmd_ff;
      cmd_in.value = req_value;
      if (load) begin
         valid_in = 1'b1;
      end else if (cmd_ready) begin
         valid_in = 1'b0;
      end
      // zero words do nothing except for clear
      case (op_type'(req_operation))
         OP_INSERT: cmd_in.kind = (req_value == '0) ? KIND_NOP : KIND_INSERT;
         OP_QUERY:  cmd_in.kind = (req_value == '0) ? KIND_NOP : KIND_QUERY;
         OP_REMOVE: cmd_in.kind = (req_value == '0) ? KIND_NOP : KIND_REMOVE;
         OP_CLEAR:  cmd_in.kind = KIND_CLEAR;
         default:   cmd_in.kind = KIND_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

/* sv/dhs_cmd_fifo.sv */
// Two-entry command queue between the front end and the engine.
`timescale 1ns / 1ps
module dhs_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  dhs_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output dhs_pkg::cmd_type out_cmd
);
   import dhs_pkg::*;

   localparam int DEPTH = 2;

   cmd_type     slot_ff [DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign in_ready  = count_ff != 2'(DEPTH);
   assign out_valid = count_ff != 2'd0;
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

/* sv/dhs_back.sv */
// Engine: bucket and node memories, chain walk, insert/remove and compaction.
`timescale 1ns / 1ps
module dhs_back #(
   parameter int TABLE_ENTRIES = dhs_pkg::DEF_TABLE_ENTRIES,
   parameter int BANK_NODES    = dhs_pkg::DEF_BANK_NODES,
   parameter int HASH_SHIFT    = dhs_pkg::DEF_HASH_SHIFT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  dhs_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dhs_pkg::rsp_type rsp_data
);
   import dhs_pkg::*;

   localparam int NODE_TOTAL = 2 * BANK_NODES;
   localparam int HB_W       = $clog2(TABLE_ENTRIES);
   localparam int NIDX_W     = $clog2(NODE_TOTAL);
   localparam int LINK_W     = $clog2(NODE_TOTAL + 1);
   localparam int CNT_W      = $clog2(BANK_NODES + 1);
   localparam int NODE_W     = VALUE_W + LINK_W;

   localparam logic [HB_W-1:0]    LAST_BUCKET = HB_W'(TABLE_ENTRIES - 1);
   localparam logic [LINK_W-1:0]  MAX_LINK    = LINK_W'(NODE_TOTAL);
   localparam logic [CNT_W-1:0]   POOL_CAP    = CNT_W'(BANK_NODES);
   localparam logic [NIDX_W-1:0]  BANK_BASE   = NIDX_W'(BANK_NODES);
   localparam logic [VALUE_W-1:0] BUCKET_MASK = VALUE_W'(TABLE_ENTRIES - 1);

   function automatic logic [HB_W-1:0] bucket_of(input logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] t;
      t = (v >> HASH_SHIFT) & BUCKET_MASK;
      return t[HB_W-1:0];
   endfunction

   function automatic logic link_ok(input logic [LINK_W-1:0] l);
      return (l != '0) && (l <= MAX_LINK);
   endfunction

   function automatic logic [NIDX_W-1:0] node_of(input logic [LINK_W-1:0] l);
      logic [LINK_W-1:0] t;
      t = l - LINK_W'(1);
      return t[NIDX_W-1:0];
   endfunction

   function automatic logic [NIDX_W-1:0] slot_index(input logic bank,
                                                    input logic [CNT_W-1:0] cnt);
      logic [NIDX_W-1:0] base;
      base = bank ? BANK_BASE : '0;
      return base + NIDX_W'(cnt);
   endfunction

   // memories
   logic [LINK_W-1:0] head_mem_ff [TABLE_ENTRIES];
   logic [NODE_W-1:0] node_mem_ff [NODE_TOTAL];
   logic [LINK_W-1:0] head_rd_ff;
   logic [NODE_W-1:0] node_rd_ff;

   logic              head_we;
   logic [HB_W-1:0]   head_wa, head_ra;
   logic [LINK_W-1:0] head_wd;
   logic              node_we;
   logic [NIDX_W-1:0] node_wa, node_ra;
   logic [NODE_W-1:0] node_wd;

   // control
   back_state_type    state_ff, state_in;
   logic [HB_W-1:0]   idx_ff, idx_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  live_ff, live_in;
   logic [CNT_W-1:0]  garbage_ff, garbage_in;
   logic              over_ff, over_in;
   logic              bank_ff, bank_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath
   kind_type          cmd_kind_ff, cmd_kind_in;
   logic [VALUE_W-1:0] cmd_value_ff, cmd_value_in;
   logic [LINK_W-1:0] head_link_ff, head_link_in;
   logic [NIDX_W-1:0] cur_ff, cur_in;
   logic              hit_ff, hit_in;
   logic [NIDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [LINK_W-1:0] hit_link_ff, hit_link_in;
   logic [CNT_W-1:0]  gc_fill_ff, gc_fill_in;
   logic [LINK_W-1:0] gc_head_ff, gc_head_in;
   rsp_type           rsp_ff, rsp_in;

   logic [VALUE_W-1:0] rd_value;
   logic [LINK_W-1:0]  rd_link;
   logic               out_free, take, rd_hit, head_ok, link_more;
   logic               has_room, gc_go, idx_last, gc_keep, rsp_load, ins_new;
   logic [NIDX_W-1:0]  new_slot, gc_slot;

   assign rd_value  = node_rd_ff[NODE_W-1 -: VALUE_W];
   assign rd_link   = node_rd_ff[LINK_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign take      = (state_ff == S_IDLE) && cmd_valid && out_free;
   assign rd_hit    = rd_value == cmd_value_ff;
   assign head_ok   = link_ok(head_rd_ff);
   assign link_more = link_ok(rd_link);
   assign has_room  = fill_ff < POOL_CAP;
   assign gc_go     = garbage_ff > (live_ff >> 1);
   assign idx_last  = idx_ff == LAST_BUCKET;
   assign gc_keep   = (rd_value != '0) && (gc_fill_ff < POOL_CAP);
   assign ins_new   = (cmd_kind_ff == KIND_INSERT) && !hit_ff;
   assign new_slot  = slot_index(bank_ff, fill_ff);
   assign gc_slot   = slot_index(!bank_ff, gc_fill_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem_ff[head_wa] <= head_wd;
      end
      head_rd_ff <= head_mem_ff[head_ra];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem_ff[node_wa] <= node_wd;
      end
      node_rd_ff <= node_mem_ff[node_ra];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_SWEEP: begin
            if (idx_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (take) begin
               case (cmd_data.kind)
                  KIND_NOP:   state_in = S_IDLE;
                  KIND_CLEAR: state_in = S_SWEEP;
                  default:    state_in = S_HEAD;
               endcase
            end
         end
         S_HEAD:    state_in = head_ok ? S_NODE : S_DECIDE;
         S_NODE: begin
            if (rd_hit || !link_more) state_in = S_DECIDE;
         end
         S_DECIDE:  state_in = (ins_new && !has_room && gc_go) ? S_GC_HEAD : S_IDLE;
         S_GC_HEAD: state_in = head_ok ? S_GC_NODE : S_GC_NEXT;
         S_GC_NODE: begin
            if (!link_more) state_in = S_GC_NEXT;
         end
         S_GC_NEXT: state_in = idx_last ? S_GC_DONE : S_GC_HEAD;
         S_GC_DONE: state_in = S_HEAD;
         default:   state_in = S_IDLE;
      endcase
   end

   // memory ports, pop and response load
   always_comb begin
      cmd_ready = 1'b0;
      rsp_load  = 1'b0;
      head_we   = 1'b0;
      head_wa   = idx_ff;
      head_wd   = '0;
      head_ra   = '0;
      node_we   = 1'b0;
      node_wa   = new_slot;
      node_wd   = {cmd_value_ff, head_link_ff};
      node_ra   = node_of(head_rd_ff);
      case (state_ff)
         S_SWEEP: begin
            head_we  = 1'b1;
            rsp_load = idx_last && clr_rsp_ff;
         end
         S_IDLE: begin
            cmd_ready = out_free;
            head_ra   = bucket_of(cmd_data.value);
            rsp_load  = take && (cmd_data.kind == KIND_NOP);
         end
         S_NODE: begin
            node_ra = node_of(rd_link);
         end
         S_DECIDE: begin
            rsp_load = !(ins_new && !has_room && gc_go);
            if (ins_new && has_room) begin
               node_we = 1'b1;
               head_we = 1'b1;
               head_wa = bucket_of(cmd_value_ff);
               head_wd = LINK_W'(new_slot) + LINK_W'(1);
            end else if ((cmd_kind_ff == KIND_REMOVE) && hit_ff) begin
               // removal keeps the link so the chain stays intact
               node_we = 1'b1;
               node_wa = hit_idx_ff;
               node_wd = {{VALUE_W{1'b0}}, hit_link_ff};
            end
         end
         S_GC_NODE: begin
            node_ra = node_of(rd_link);
            node_we = gc_keep;
            node_wa = gc_slot;
            node_wd = {rd_value, gc_head_ff};
         end
         S_GC_NEXT: begin
            head_we = 1'b1;
            head_wd = gc_head_ff;
            head_ra = idx_ff + HB_W'(1);
         end
         S_GC_DONE: begin
            head_ra = bucket_of(cmd_value_ff);
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      idx_in       = idx_ff;
      clr_rsp_in   = clr_rsp_ff;
      fill_in      = fill_ff;
      live_in      = live_ff;
      garbage_in   = garbage_ff;
      over_in      = over_ff;
      bank_in      = bank_ff;
      cmd_kind_in  = cmd_kind_ff;
      cmd_value_in = cmd_value_ff;
      head_link_in = head_link_ff;
      cur_in       = cur_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_link_in  = hit_link_ff;
      gc_fill_in   = gc_fill_ff;
      gc_head_in   = gc_head_ff;
      case (state_ff)
         S_SWEEP: begin
            if (idx_last) begin
               idx_in     = '0;
               clr_rsp_in = 1'b0;
            end else begin
               idx_in = idx_ff + HB_W'(1);
            end
         end
         S_IDLE: begin
            if (take) begin
               cmd_kind_in  = cmd_data.kind;
               cmd_value_in = cmd_data.value;
               hit_in       = 1'b0;
               if (cmd_data.kind == KIND_CLEAR) begin
                  idx_in     = '0;
                  clr_rsp_in = 1'b1;
                  fill_in    = '0;
                  live_in    = '0;
                  garbage_in = '0;
                  over_in    = 1'b0;
               end
            end
         end
         S_HEAD: begin
            head_link_in = head_rd_ff;
            hit_in       = 1'b0;
            cur_in       = node_of(head_rd_ff);
         end
         S_NODE: begin
            if (rd_hit) begin
               hit_in      = 1'b1;
               hit_idx_in  = cur_ff;
               hit_link_in = rd_link;
            end else begin
               cur_in = node_of(rd_link);
            end
         end
         S_DECIDE: begin
            if (ins_new) begin
               if (has_room) begin
                  fill_in = fill_ff + CNT_W'(1);
                  live_in = live_ff + CNT_W'(1);
               end else if (gc_go) begin
                  idx_in     = '0;
                  gc_fill_in = '0;
               end else begin
                  over_in = 1'b1;
               end
            end else if ((cmd_kind_ff == KIND_REMOVE) && hit_ff) begin
               if (live_ff != '0) live_in = live_ff - CNT_W'(1);
               garbage_in = garbage_ff + CNT_W'(1);
            end
         end
         S_GC_HEAD: begin
            gc_head_in = '0;
         end
         S_GC_NODE: begin
            if (gc_keep) begin
               gc_head_in = LINK_W'(gc_slot) + LINK_W'(1);
               gc_fill_in = gc_fill_ff + CNT_W'(1);
            end
         end
         S_GC_NEXT: begin
            if (idx_last) begin
               idx_in     = '0;
               bank_in    = !bank_ff;
               fill_in    = gc_fill_ff;
               live_in    = gc_fill_ff;
               garbage_in = '0;
            end else begin
               idx_in = idx_ff + HB_W'(1);
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_in                 = rsp_ff;
      rsp_in.was_present     = (state_ff == S_DECIDE) && hit_ff;
      rsp_in.was_added       = (state_ff == S_DECIDE) && ins_new && has_room;
      rsp_in.overflowed      = over_in;
      rsp_in.live_entries    = COUNT_W'(live_in);
      rsp_in.garbage_entries = COUNT_W'(garbage_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         idx_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         fill_ff      <= '0;
         live_ff      <= '0;
         garbage_ff   <= '0;
         over_ff      <= 1'b0;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clr_rsp_ff   <= clr_rsp_in;
         fill_ff      <= fill_in;
         live_ff      <= live_in;
         garbage_ff   <= garbage_in;
         over_ff      <= over_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_kind_ff  <= cmd_kind_in;
      cmd_value_ff <= cmd_value_in;
      head_link_ff <= head_link_in;
      cur_ff       <= cur_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_link_ff  <= hit_link_in;
      gc_fill_ff   <= gc_fill_in;
      gc_head_ff   <= gc_head_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* sv/dedup_hash_set_with_pool_gc.sv */
// Top level of the dedup hash set with node pool compaction.
`timescale 1ns / 1ps
// Set of nonzero 64-bit words kept in a chained hash table, bucket picked by
// (value >> HASH_SHIFT) masked to TABLE_ENTRIES, nodes drawn from one of two
// banks of BANK_NODES. Each request word (insert, query, remove, clear)
// gives one response word. Lookups walk the chain in the node memory, one
// registered read per node: an item holds the engine through take and head
// read, head check, one step per node visited, and decide, and the engine
// takes no new item until its response is loaded. Zero-value inserts, queries
// and removes are answered from idle without a walk. Clear sweeps the bucket
// memory; the same sweep runs after reset before the first request is taken.
// An insert that finds the bank full with enough garbage compacts all chains
// into the other bank first, visiting every bucket and every node in the old
// chains. A two-entry queue and an input register let requests arrive while
// the engine or the response side stalls.
module dedup_hash_set_with_pool_gc #(
   parameter int TABLE_ENTRIES = dhs_pkg::DEF_TABLE_ENTRIES,
   parameter int BANK_NODES    = dhs_pkg::DEF_BANK_NODES,
   parameter int HASH_SHIFT    = dhs_pkg::DEF_HASH_SHIFT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [dhs_pkg::OP_W-1:0]     req_operation,
   input  logic [dhs_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_was_present,
   output logic                         rsp_was_added,
   output logic                         rsp_overflowed,
   output logic [dhs_pkg::COUNT_W-1:0]  rsp_live_entries,
   output logic [dhs_pkg::COUNT_W-1:0]  rsp_garbage_entries
);
   import dhs_pkg::*;

   logic    front_valid, front_ready;
   cmd_type front_cmd;
   logic    queue_valid, queue_ready;
   cmd_type queue_cmd;
   rsp_type rsp_word;

   dhs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_value     (req_value),
      .cmd_valid     (front_valid),
      .cmd_ready     (front_ready),
      .cmd_data      (front_cmd)
   );

   dhs_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_cmd   (queue_cmd)
   );

   dhs_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .BANK_NODES    (BANK_NODES),
      .HASH_SHIFT    (HASH_SHIFT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd_data  (queue_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_word)
   );

   assign rsp_was_present     = rsp_word.was_present;
   assign rsp_was_added       = rsp_word.was_added;
   assign rsp_overflowed      = rsp_word.overflowed;
   assign rsp_live_entries    = rsp_word.live_entries;
   assign rsp_garbage_entries = rsp_word.garbage_entries;

endmodule

/* sv/dhs_checker.sv */
// Port-level checks for the dedup hash set, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dhs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_was_present,
   input logic                         rsp_was_added,
   input logic                         rsp_overflowed,
   input logic [dhs_pkg::COUNT_W-1:0]  rsp_live_entries,
   input logic [dhs_pkg::COUNT_W-1:0]  rsp_garbage_entries
);
   import dhs_pkg::*;

   // a new node is only made for a value that was absent
   `DHS_ASSERT_IMP(added_not_present, clock, reset, rsp_valid && rsp_was_added, !rsp_was_present)

   // a fresh insert always leaves at least one live node
   `DHS_ASSERT_IMP(added_has_live, clock, reset, rsp_valid && rsp_was_added, rsp_live_entries != '0)

   // stalled response word holds
   `DHS_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_was_present) && $stable(rsp_was_added) && $stable(rsp_overflowed) && $stable(rsp_live_entries) && $stable(rsp_garbage_entries))

endmodule

bind dedup_hash_set_with_pool_gc dhs_checker u_dhs_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_was_present     (rsp_was_present),
   .rsp_was_added       (rsp_was_added),
   .rsp_overflowed      (rsp_overflowed),
   .rsp_live_entries    (rsp_live_entries),
   .rsp_garbage_entries (rsp_garbage_entries)
);

/* sim/tb_dedup_hash_set_with_pool_gc.sv */
// Testbench for the dedup hash set with node pool compaction.
`timescale 1ns / 1ps
module tb_dedup_hash_set_with_pool_gc;
   import dhs_pkg::*;

   localparam int TABLE_N   = DEF_TABLE_ENTRIES;
   localparam int POOL_N    = DEF_BANK_NODES;
   localparam int SHIFT_N   = DEF_HASH_SHIFT;
   localparam int NODE_N    = 2 * POOL_N;
   localparam int STALL_MAX = 20000;
   localparam int KEY_N     = 64;

   typedef struct {
      logic               drain;
      op_type             op;
      logic [VALUE_W-1:0] value;
   } req_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_operation = OP_INSERT;
   logic [VALUE_W-1:0]   req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_was_present;
   logic                 rsp_was_added;
   logic                 rsp_overflowed;
   logic [COUNT_W-1:0]   rsp_live_entries;
   logic [COUNT_W-1:0]   rsp_garbage_entries;

   dedup_hash_set_with_pool_gc DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_was_present(rsp_was_present), .rsp_was_added(rsp_was_added),
      .rsp_overflowed(rsp_overflowed), .rsp_live_entries(rsp_live_entries),
      .rsp_garbage_entries(rsp_garbage_entries)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // shadow copy of the set
   int unsigned    set_heads [TABLE_N];
   logic [63:0]    node_val [NODE_N];
   int unsigned    node_next [NODE_N];
   int unsigned    pool_used;
   int unsigned    bank_sel;
   int unsigned    live_cnt;
   int unsigned    garbage_cnt;
   logic           overflow_seen;

   req_word_type   pending_q [$];
   rsp_type        expected_q [$];
   int             words_sent;
   int             words_total;
   int             words_checked;
   int             mismatches;
   int             hold_left;
   bit             hold_done;
   int             stall_cycles;
   logic [63:0]    key_pool [KEY_N];
   logic [63:0]    fill_vals [$];

   function automatic int unsigned bucket_of(logic [63:0] v);
      return int'((v >> SHIFT_N) & (TABLE_N - 1));
   endfunction

   function automatic int unsigned find_link(logic [63:0] v);
      int unsigned p;
      int unsigned steps;
      p = set_heads[bucket_of(v)];
      steps = 0;
      while (p != 0 && steps < NODE_N) begin
         if (p - 1 >= NODE_N) return 0;
         if (node_val[p-1] == v) return p;
         p = node_next[p-1];
         steps++;
      end
      return 0;
   endfunction

   // move every live node into the other bank, dropping removed ones
   function automatic void compact_pool();
      int unsigned nb;
      int unsigned base;
      int unsigned fill;
      int unsigned p;
      int unsigned steps;
      int unsigned n;
      nb = bank_sel ^ 1;
      base = nb * POOL_N;
      fill = 0;
      for (int h = 0; h < TABLE_N; h++) begin
         p = set_heads[h];
         steps = 0;
         set_heads[h] = 0;
         while (p != 0 && steps < NODE_N) begin
            if (p - 1 >= NODE_N) break;
            if (node_val[p-1] != 0 && fill < POOL_N) begin
               n = base + fill;
               node_val[n] = node_val[p-1];
               node_next[n] = set_heads[h];
               set_heads[h] = n + 1;
               fill++;
            end
            p = node_next[p-1];
            steps++;
         end
      end
      bank_sel = nb;
      pool_used = fill;
      live_cnt = fill;
      garbage_cnt = 0;
   endfunction

   function automatic rsp_type predict_word(op_type op, logic [63:0] v);
      rsp_type r;
      int unsigned hit;
      int unsigned b;
      int unsigned n;
      bit room;
      r = '0;
      if (op == OP_CLEAR) begin
         foreach (set_heads[i]) set_heads[i] = 0;
         pool_used = 0;
         live_cnt = 0;
         garbage_cnt = 0;
         overflow_seen = 1'b0;
      end else if (v != 0) begin
         hit = find_link(v);
         r.was_present = (hit != 0);
         if (op == OP_INSERT && hit == 0) begin
            room = 1'b1;
            if (pool_used >= POOL_N) begin
               if (garbage_cnt > live_cnt / 2) compact_pool();
               room = (pool_used < POOL_N);
               if (!room) overflow_seen = 1'b1;
            end
            if (room) begin
               b = bucket_of(v);
               n = bank_sel * POOL_N + pool_used;
               node_val[n] = v;
               node_next[n] = set_heads[b];
               set_heads[b] = n + 1;
               pool_used++;
               live_cnt++;
               r.was_added = 1'b1;
            end
         end else if (op == OP_REMOVE && hit != 0) begin
            node_val[hit-1] = '0;
            if (live_cnt > 0) live_cnt--;
            garbage_cnt++;
         end
      end
      r.overflowed = overflow_seen;
      r.live_entries = live_cnt[COUNT_W-1:0];
      r.garbage_entries = garbage_cnt[COUNT_W-1:0];
      return r;
   endfunction

   function automatic int idle_pct(bit sender);
      int ph;
      ph = (words_total == 0) ? 0 : words_sent * 3 / words_total;
      if (ph == 0) return sender ? 31 : 69;
      if (ph == 1) return sender ? 69 : 31;
      return 0;
   endfunction

   task automatic push_word(op_type op, logic [63:0] v);
      req_word_type w;
      w.drain = 1'b0;
      w.op = op;
      w.value = v;
      pending_q.push_back(w);
   endtask

   task automatic push_drain();
      req_word_type w;
      w.drain = 1'b1;
      w.op = OP_QUERY;
      w.value = '0;
      pending_q.push_back(w);
   endtask

   // distinct nonzero value: index in the top bits, random elsewhere
   function automatic logic [63:0] fresh_value(int idx);
      return {idx[15:0] + 16'd1, 16'($urandom), $urandom};
   endfunction

   task automatic push_mixed(int count);
      int r;
      logic [63:0] v;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         v = key_pool[$urandom_range(KEY_N - 1)];
         if ($urandom_range(9) == 0) v = {$urandom, $urandom};
         if (r < 5) push_word(op_type'($urandom_range(2)), '0);
         else if (r < 8) push_word(OP_CLEAR, {$urandom, $urandom});
         else if (r < 45) push_word(OP_INSERT, v);
         else if (r < 65) push_word(OP_QUERY, v);
         else push_word(OP_REMOVE, v);
      end
   endtask

   // sender
   always @(posedge clock) begin
      req_word_type nxt;
      bit go;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_q.push_back(predict_word(op_type'(req_operation), req_value));
            words_sent++;
         end
         if (!(req_valid && !req_ready)) begin
            go = 1'b0;
            if (pending_q.size() > 0) begin
               if (pending_q[0].drain) begin
                  if (expected_q.size() == 0) void'(pending_q.pop_front());
               end else if ($urandom_range(99) >= idle_pct(1'b1)) begin
                  nxt = pending_q.pop_front();
                  go = 1'b1;
               end
            end
            req_valid <= go;
            if (go) begin
               req_operation <= nxt.op;
               req_value <= nxt.value;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response word with nothing expected");
               mismatches++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_was_present !== e.was_present) begin
                  $error("was_present expected %0d got %0d", e.was_present, rsp_was_present);
                  mismatches++;
               end
               if (rsp_was_added !== e.was_added) begin
                  $error("was_added expected %0d got %0d", e.was_added, rsp_was_added);
                  mismatches++;
               end
               if (rsp_overflowed !== e.overflowed) begin
                  $error("overflowed expected %0d got %0d", e.overflowed, rsp_overflowed);
                  mismatches++;
               end
               if (rsp_live_entries !== e.live_entries) begin
                  $error("live_entries expected %0d got %0d",
                         e.live_entries, rsp_live_entries);
                  mismatches++;
               end
               if (rsp_garbage_entries !== e.garbage_entries) begin
                  $error("garbage_entries expected %0d got %0d",
                         e.garbage_entries, rsp_garbage_entries);
                  mismatches++;
               end
            end
            words_checked++;
         end
         // one long back-pressure stretch so the input side fills and stalls
         if (!hold_done && words_checked >= 400) begin
            hold_done = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct(1'b0));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_MAX) begin
            $display("tb_dedup_hash_set_with_pool_gc NOT OK");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] v;
      words_sent = 0;
      words_total = 0;
      words_checked = 0;
      mismatches = 0;
      hold_left = 0;
      hold_done = 1'b0;
      stall_cycles = 0;
      foreach (set_heads[i]) set_heads[i] = 0;
      foreach (node_val[i]) node_val[i] = '0;
      foreach (node_next[i]) node_next[i] = 0;
      pool_used = 0;
      bank_sel = 0;
      live_cnt = 0;
      garbage_cnt = 0;
      overflow_seen = 1'b0;

      // key pool; every fourth key shares one bucket to build a chain
      for (int i = 0; i < KEY_N; i++) begin
         v = {$urandom, $urandom};
         if (i % 4 == 0) v[13:4] = 10'h155;
         if (v == 0) v = 64'd1;
         key_pool[i] = v;
      end

      // directed
      push_word(OP_INSERT, '0);
      push_word(OP_QUERY, '0);
      push_word(OP_REMOVE, '0);
      push_word(OP_INSERT, '1);
      push_word(OP_INSERT, 64'd1);
      push_word(OP_INSERT, 64'h0000_0001_0000_0001);   // same bucket as 1
      push_word(OP_INSERT, 64'd1);
      push_word(OP_QUERY, 64'd1);
      push_word(OP_QUERY, 64'h0000_0001_0000_0001);
      push_word(OP_QUERY, 64'h8000_0000_0000_0000);
      push_word(OP_REMOVE, 64'd1);
      push_word(OP_REMOVE, 64'd1);
      push_word(OP_QUERY, 64'd1);
      push_word(OP_INSERT, 64'd1);
      push_word(OP_QUERY, '1);
      push_word(OP_INSERT, 64'h8000_0000_0000_0000);
      push_word(OP_CLEAR, '1);
      push_word(OP_QUERY, '1);
      push_word(OP_INSERT, '1);
      push_drain();

      push_mixed(350);
      push_drain();

      // fill the bank, overflow, then free enough to force compaction
      push_word(OP_CLEAR, '0);
      for (int i = 0; i < POOL_N; i++) begin
         v = fresh_value(i);
         fill_vals.push_back(v);
         push_word(OP_INSERT, v);
      end
      push_word(OP_INSERT, fresh_value(POOL_N));
      push_word(OP_QUERY, fill_vals[5]);
      push_word(OP_INSERT, fill_vals[7]);
      for (int i = 0; i < 350; i++) push_word(OP_REMOVE, fill_vals[2 * i]);
      push_word(OP_INSERT, fresh_value(POOL_N + 1));
      for (int i = 0; i < 20; i++) push_word(OP_QUERY, fill_vals[$urandom_range(POOL_N - 1)]);
      push_mixed(150);
      push_word(OP_CLEAR, '0);
      push_mixed(100);

      foreach (pending_q[i]) if (!pending_q[i].drain) words_total++;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (30) @(posedge clock);
      if (mismatches == 0)
         $display("tb_dedup_hash_set_with_pool_gc OK");
      else
         $display("tb_dedup_hash_set_with_pool_gc NOT OK");
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/dhs_pkg.sv
sv/dhs_front.sv
sv/dhs_cmd_fifo.sv
sv/dhs_back.sv
sv/dedup_hash_set_with_pool_gc.sv
sv/dhs_checker.sv
sim/tb_dedup_hash_set_with_pool_gc.sv
